// ===== hdl/irpdt_pkg.sv =====
`default_nettype none

package irpdt_pkg;

    localparam int NUM_CODES            = 16;
    localparam int FRAME_BITS           = 64;
    localparam int TICK_COUNT_WIDTH_DEF = 16;

    localparam int CODE_W    = 4;
    localparam int BIT_W     = 6;
    localparam int WORD_W    = 64;
    localparam int DUR_W     = 16;
    localparam int CFG_IDX_W = 3;

    // timing register reset values
    localparam logic [DUR_W-1:0] HDR_MARK_RST   = 16'd6100;
    localparam logic [DUR_W-1:0] HDR_SPACE_RST  = 16'd7600;
    localparam logic [DUR_W-1:0] BIT_MARK_RST   = 16'd500;
    localparam logic [DUR_W-1:0] ZERO_SPACE_RST = 16'd1500;
    localparam logic [DUR_W-1:0] ONE_SPACE_RST  = 16'd3500;
    localparam logic [DUR_W-1:0] STOP_SPACE_RST = 16'd7600;

    // marks have odd codes
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HMARK,
        PH_HSPACE,
        PH_BMARK,
        PH_BSPACE,
        PH_SMARK1,
        PH_SSPACE,
        PH_SMARK2
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HDR_MARK,
        CFG_HDR_SPACE,
        CFG_BIT_MARK,
        CFG_ZERO_SPACE,
        CFG_ONE_SPACE,
        CFG_STOP_SPACE
    } cfg_reg_t;

    typedef struct packed {
        logic [DUR_W-1:0] header_mark;
        logic [DUR_W-1:0] header_space;
        logic [DUR_W-1:0] bit_mark;
        logic [DUR_W-1:0] zero_space;
        logic [DUR_W-1:0] one_space;
        logic [DUR_W-1:0] stop_space;
    } timing_t;

    typedef struct packed {
        logic carrier_on;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } result_t;

    // stored frame codes, byte 0 in the low bits
    function automatic logic [WORD_W-1:0] code_word(input logic [CODE_W-1:0] idx);
        logic [WORD_W-1:0] w;
        case (idx)
            4'd0:    w = 64'hDFDFAFF52020500A;
            4'd1:    w = 64'hDF5FAFF520A0500A;
            4'd2:    w = 64'hDF5EAFF520A1500A;
            4'd3:    w = 64'hDF5DAFF520A2500A;
            4'd4:    w = 64'hDF5CAFF520A3500A;
            4'd5:    w = 64'hDF5BAFF520A4500A;
            4'd6:    w = 64'hDF5AAFF520A5500A;
            4'd7:    w = 64'hDF59AFF520A6500A;
            4'd8:    w = 64'hDF58AFF520A7500A;
            4'd9:    w = 64'hDF57AFF520A8500A;
            4'd10:   w = 64'hDF56AFF520A9500A;
            4'd11:   w = 64'hDF55AFF520AA500A;
            4'd12:   w = 64'hDF54AFF520AB500A;
            4'd13:   w = 64'hDF53AFF520AC500A;
            4'd14:   w = 64'hDF52AFF520AD500A;
            default: w = 64'hDF51AFF520AE500A;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/irpdt_if.sv =====
`default_nettype none

interface irpdt_req_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [irpdt_pkg::CODE_W-1:0]   code;
    modport source (output valid, mode, code, input ready);
    modport sink   (input valid, mode, code, output ready);
endinterface

interface irpdt_rsp_if;
    logic valid;
    logic ready;
    logic carrier_on;
    logic busy_res;
    logic frame_done;
    logic rejected;
    modport source (output valid, carrier_on, busy_res, frame_done, rejected, input ready);
    modport sink   (input valid, carrier_on, busy_res, frame_done, rejected, output ready);
endinterface

interface irpdt_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [irpdt_pkg::CFG_IDX_W-1:0]   index;
    logic [irpdt_pkg::DUR_W-1:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/irpdt_frame.sv =====
`default_nettype none

module irpdt_frame #(
    parameter int TICK_COUNT_WIDTH = irpdt_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic                          mode,
    input  wire logic [irpdt_pkg::CODE_W-1:0]  code,
    input  wire irpdt_pkg::timing_t            timing,
    output irpdt_pkg::result_t                 result
);
    import irpdt_pkg::*;

    localparam int CW = TICK_COUNT_WIDTH;
    localparam int EW = (CW > DUR_W) ? CW : DUR_W;

    typedef logic [CW-1:0] cnt_t;

    function automatic cnt_t clamp(input logic [DUR_W-1:0] v);
        logic [EW-1:0] ve;
        ve = EW'(v);
        if (ve > EW'({CW{1'b1}}))
        begin
            return '1;
        end
        return CW'(ve);
    endfunction

    phase_t             phase_reg, phase_next;
    cnt_t               remain_reg, remain_next;
    logic [BIT_W-1:0]   bitpos_reg, bitpos_next;
    logic [CODE_W-1:0]  sel_reg, sel_next;

    logic [WORD_W-1:0]  word;
    cnt_t               len_hm, len_hs, len_bm, len_s0, len_s1, len_ss;
    logic               hs_nz, bm_nz, z_nz, o_nz, ss_nz;
    logic [WORD_W-1:0]  spc_nz, above, cand, iso;
    logic               found;
    logic [BIT_W-1:0]   idx, srch_start;
    logic [BIT_W:0]     bit_plus;
    logic               has_next;
    cnt_t               space_b;
    logic               code_ok;

    // zero-length phase skipping
    phase_t             tl_ph, sr_ph, be_ph, rs_ph;
    cnt_t               tl_len, sr_len, be_len, rs_len;
    logic [BIT_W-1:0]   sr_bit, be_bit, rs_bit;

    // phase in force for this tick
    phase_t             cur_ph;
    cnt_t               cur_len, dec;
    logic [BIT_W-1:0]   cur_bit;
    logic [BIT_W:0]     cur_plus;
    logic               ended, dec_zero;

    phase_t             adv_ph;
    cnt_t               adv_len;
    logic [BIT_W-1:0]   adv_bit;

    always_comb
    begin
        word     = code_word(sel_reg);
        len_hm   = clamp(timing.header_mark);
        len_hs   = clamp(timing.header_space);
        len_bm   = clamp(timing.bit_mark);
        len_s0   = clamp(timing.zero_space);
        len_s1   = clamp(timing.one_space);
        len_ss   = clamp(timing.stop_space);
        hs_nz    = timing.header_space != '0;
        bm_nz    = timing.bit_mark != '0;
        z_nz     = timing.zero_space != '0;
        o_nz     = timing.one_space != '0;
        ss_nz    = timing.stop_space != '0;
        bit_plus = {1'b0, bitpos_reg} + (BIT_W+1)'(1);
        has_next = int'(bit_plus) < FRAME_BITS;
        space_b  = word[bitpos_reg] ? len_s1 : len_s0;
        code_ok  = int'(code) < NUM_CODES;
    end

    // first data bit at or after the start whose space is not empty
    always_comb
    begin
        case (phase_reg)
            PH_HMARK, PH_HSPACE: srch_start = '0;
            PH_BMARK:            srch_start = bitpos_reg;
            default:             srch_start = bit_plus[BIT_W-1:0];
        endcase
        for (int k = 0; k < WORD_W; k++)
        begin
            spc_nz[k] = (k < FRAME_BITS) && (word[k] ? o_nz : z_nz);
            above[k]  = k >= int'(srch_start);
        end
        cand  = spc_nz & above;
        iso   = cand & (~cand + WORD_W'(1));
        found = |cand;
        idx   = '0;
        for (int k = 0; k < WORD_W; k++)
        begin
            idx = idx | (iso[k] ? BIT_W'(k) : '0);
        end
    end

    always_comb
    begin
        // stop sequence from the first stop mark
        if (bm_nz)
        begin
            tl_ph  = PH_SMARK1;
            tl_len = len_bm;
        end
        else if (ss_nz)
        begin
            tl_ph  = PH_SSPACE;
            tl_len = len_ss;
        end
        else
        begin
            tl_ph  = PH_IDLE;
            tl_len = '0;
        end

        if (found)
        begin
            sr_ph  = PH_BSPACE;
            sr_bit = idx;
            sr_len = word[idx] ? len_s1 : len_s0;
        end
        else
        begin
            sr_ph  = tl_ph;
            sr_bit = bitpos_reg;
            sr_len = tl_len;
        end

        // entering a bit mark at the search start
        if (bm_nz)
        begin
            be_ph  = PH_BMARK;
            be_bit = srch_start;
            be_len = len_bm;
        end
        else
        begin
            be_ph  = sr_ph;
            be_bit = sr_bit;
            be_len = sr_len;
        end

        rs_ph  = PH_IDLE;
        rs_bit = bitpos_reg;
        rs_len = '0;
        case (phase_reg)
            PH_HMARK:
            begin
                if (hs_nz)
                begin
                    rs_ph  = PH_HSPACE;
                    rs_len = len_hs;
                end
                else
                begin
                    rs_ph  = be_ph;
                    rs_bit = be_bit;
                    rs_len = be_len;
                end
            end
            PH_HSPACE:
            begin
                rs_ph  = be_ph;
                rs_bit = be_bit;
                rs_len = be_len;
            end
            PH_BMARK:
            begin
                if (spc_nz[bitpos_reg])
                begin
                    rs_ph  = PH_BSPACE;
                    rs_len = space_b;
                end
                else if (bm_nz && has_next)
                begin
                    rs_ph  = PH_BMARK;
                    rs_bit = bit_plus[BIT_W-1:0];
                    rs_len = len_bm;
                end
                else if (bm_nz)
                begin
                    rs_ph  = tl_ph;
                    rs_len = tl_len;
                end
                else
                begin
                    rs_ph  = sr_ph;
                    rs_bit = sr_bit;
                    rs_len = sr_len;
                end
            end
            PH_BSPACE:
            begin
                if (has_next)
                begin
                    rs_ph  = be_ph;
                    rs_bit = be_bit;
                    rs_len = be_len;
                end
                else
                begin
                    rs_ph  = tl_ph;
                    rs_len = tl_len;
                end
            end
            PH_SMARK1:
            begin
                if (ss_nz)
                begin
                    rs_ph  = PH_SSPACE;
                    rs_len = len_ss;
                end
                else if (bm_nz)
                begin
                    rs_ph  = PH_SMARK2;
                    rs_len = len_bm;
                end
            end
            PH_SSPACE:
            begin
                if (bm_nz)
                begin
                    rs_ph  = PH_SMARK2;
                    rs_len = len_bm;
                end
            end
            default:
            begin
                rs_ph = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (remain_reg != '0)
        begin
            cur_ph  = phase_reg;
            cur_bit = bitpos_reg;
            cur_len = remain_reg;
        end
        else
        begin
            cur_ph  = rs_ph;
            cur_bit = rs_bit;
            cur_len = rs_len;
        end
        ended    = cur_ph == PH_IDLE;
        dec      = cur_len - CW'(1);
        dec_zero = dec == '0;
        cur_plus = {1'b0, cur_bit} + (BIT_W+1)'(1);

        // load of the following phase once this one runs out
        adv_bit = cur_bit;
        case (cur_ph)
            PH_HMARK:
            begin
                adv_ph  = PH_HSPACE;
                adv_len = len_hs;
            end
            PH_HSPACE:
            begin
                adv_ph  = PH_BMARK;
                adv_bit = '0;
                adv_len = len_bm;
            end
            PH_BMARK:
            begin
                adv_ph  = PH_BSPACE;
                adv_len = word[cur_bit] ? len_s1 : len_s0;
            end
            PH_BSPACE:
            begin
                if (int'(cur_plus) < FRAME_BITS)
                begin
                    adv_ph  = PH_BMARK;
                    adv_bit = cur_plus[BIT_W-1:0];
                end
                else
                begin
                    adv_ph  = PH_SMARK1;
                end
                adv_len = len_bm;
            end
            PH_SMARK1:
            begin
                adv_ph  = PH_SSPACE;
                adv_len = len_ss;
            end
            PH_SSPACE:
            begin
                adv_ph  = PH_SMARK2;
                adv_len = len_bm;
            end
            default:
            begin
                adv_ph  = PH_IDLE;
                adv_len = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        bitpos_next = bitpos_reg;
        sel_next    = sel_reg;
        if (step)
        begin
            if (mode)
            begin
                if (phase_reg == PH_IDLE && code_ok)
                begin
                    sel_next    = code;
                    bitpos_next = '0;
                    phase_next  = PH_HMARK;
                    remain_next = len_hm;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (ended)
                begin
                    phase_next  = PH_IDLE;
                    remain_next = '0;
                end
                else if (dec_zero)
                begin
                    phase_next  = adv_ph;
                    bitpos_next = adv_bit;
                    remain_next = adv_len;
                end
                else
                begin
                    phase_next  = cur_ph;
                    bitpos_next = cur_bit;
                    remain_next = dec;
                end
            end
        end
    end

    // result of this word
    always_comb
    begin
        result = '0;
        if (mode)
        begin
            if (phase_reg != PH_IDLE)
            begin
                result.rejected = 1'b1;
                result.busy_res = 1'b1;
            end
            else if (code_ok)
            begin
                result.busy_res = 1'b1;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            result.busy_res = 1'b1;
            if (ended)
            begin
                result.frame_done = 1'b1;
            end
            else
            begin
                result.carrier_on = cur_ph[0];
                result.frame_done = dec_zero && (cur_ph == PH_SMARK2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            remain_reg <= '0;
            bitpos_reg <= '0;
            sel_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            bitpos_reg <= bitpos_next;
            sel_reg    <= sel_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ir_pulse_distance_transmitter.sv =====
// a result word is registered and presented in the cycle after its input word is accepted
// throughput: one input word per cycle unless rsp stalls; the phase counter,
// zero-length skip and next-phase load are all combinational, which sets that rate
// reset: timing registers return to their defaults, transmitter goes idle,
// output register empties
`default_nettype none

module ir_pulse_distance_transmitter #(
    parameter int TICK_COUNT_WIDTH = irpdt_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    irpdt_req_if.sink  req,
    irpdt_rsp_if.source rsp,
    irpdt_cfg_if.sink  cfg
);
    import irpdt_pkg::*;

    // timing registers, written only between frames by convention
    timing_t  timing_reg, timing_next;

    // output register
    result_t  res_reg;
    result_t  core_res;
    logic     out_valid_reg, out_valid_next;
    logic     in_acc;

    // config port never stalls
    assign cfg.ready = 1'b1;

    always_comb
    begin
        timing_next = timing_reg;
        if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                CFG_HDR_MARK:   timing_next.header_mark  = cfg.data;
                CFG_HDR_SPACE:  timing_next.header_space = cfg.data;
                CFG_BIT_MARK:   timing_next.bit_mark     = cfg.data;
                CFG_ZERO_SPACE: timing_next.zero_space   = cfg.data;
                CFG_ONE_SPACE:  timing_next.one_space    = cfg.data;
                CFG_STOP_SPACE: timing_next.stop_space   = cfg.data;
                default:        timing_next = timing_reg;   // unused indexes dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.header_mark  <= HDR_MARK_RST;
            timing_reg.header_space <= HDR_SPACE_RST;
            timing_reg.bit_mark     <= BIT_MARK_RST;
            timing_reg.zero_space   <= ZERO_SPACE_RST;
            timing_reg.one_space    <= ONE_SPACE_RST;
            timing_reg.stop_space   <= STOP_SPACE_RST;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

    // a new word enters whenever the output register is empty or being drained
    assign req.ready = !out_valid_reg || rsp.ready;
    assign in_acc    = req.valid && req.ready;

    // frame sequencer: state advances only on accepted words
    irpdt_frame #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_acc),
        .mode   (req.mode),
        .code   (req.code),
        .timing (timing_reg),
        .result (core_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_acc)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            res_reg <= core_res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.carrier_on = res_reg.carrier_on;
    assign rsp.busy_res   = res_reg.busy_res;
    assign rsp.frame_done = res_reg.frame_done;
    assign rsp.rejected   = res_reg.rejected;

    // every accepted word leaves a result behind
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid_reg)
        else $error("accepted word produced no result");

    // a rejected command takes no time on the air
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.rejected |->
            res_reg.busy_res && !res_reg.carrier_on && !res_reg.frame_done)
        else $error("rejected result carries frame activity");

    // carrier and frame end only inside a frame
    a_carrier_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.carrier_on || res_reg.frame_done) |-> res_reg.busy_res)
        else $error("carrier or frame end outside a frame");

endmodule

`default_nettype wire
